>>> hw/rtl/ilid_pkg.sv
// shared types and codes for the indexed list insert/delete core
// no dependencies
package ilid_pkg;

   typedef enum logic [1:0] {
      FN_APPEND = 2'd0,
      FN_INSERT = 2'd1,
      FN_DELETE = 2'd2,
      FN_READ   = 2'd3
   } ilid_func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } ilid_status_type;

   localparam int DATA_W  = 32;
   localparam int POS_IN_W = 5;
   localparam int CNT_OUT_W = 5;

   typedef struct packed {
      logic              ins_en;
      logic              del_en;
      logic [DATA_W-1:0] value;
   } ilid_cmd_type;

   typedef struct packed {
      ilid_status_type      status;
      logic [CNT_OUT_W-1:0] count;
      logic [DATA_W-1:0]    read_value;
   } ilid_rsp_type;

endpackage

>>> hw/rtl/indexed_list_insert_delete_core.sv
// top level of the indexed list insert/delete core
// depends on ilid_pkg, ilid_cell, ilid_rsp_buf
//
// Bounded ordered list of CAPACITY signed 32-bit words held in a chain of
// cells, one entry per cell. Append, insert, delete and read each take one
// transaction per clock while req_ready is high: on acceptance every cell
// above the position (on delete, also the one at it) loads its neighbor in
// the same cycle, so the list is updated at once and the next transaction
// may follow in the next cycle. A two-entry result buffer keeps req_ready
// high unless two results are waiting. Reads reach the first 32 entries
// (the position port is 5 bits); rsp_count is the entry count truncated to
// 5 bits. Entries need no clearing after reset.
module indexed_list_insert_delete_core
   import ilid_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [4:0]          req_position,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [4:0]          rsp_count,
   output logic signed [31:0]  rsp_read_value
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;
   localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  shift_pos;
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] read_mux;
   logic [CMP_W-1:0]  pos_c;
   logic [CMP_W-1:0]  cnt_c;
   logic              full;
   logic              accept;
   ilid_func_type     fn;
   ilid_cmd_type      cmd;
   ilid_rsp_type      rsp_new;
   ilid_rsp_type      rsp_out;

   assign accept = req_valid && req_ready;
   assign fn     = ilid_func_type'(req_func);
   assign pos_c  = CMP_W'(req_position);
   assign cnt_c  = CMP_W'(count_ff);
   assign full   = count_ff == CNT_W'(CAPACITY);

   always_comb begin
      read_mux = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (req_position == POS_IN_W'(i)) begin
            read_mux = read_mux | cell_data[i];
         end
      end
   end

   always_comb begin
      cmd.ins_en         = 1'b0;
      cmd.del_en         = 1'b0;
      cmd.value          = req_value;
      shift_pos          = CNT_W'(req_position);
      count_in           = count_ff;
      rsp_new.status     = ST_DONE;
      rsp_new.read_value = '0;
      unique case (fn)
         FN_APPEND: begin
            if (full) begin
               rsp_new.status = ST_FULL;
            end else begin
               cmd.ins_en = 1'b1;
               shift_pos  = count_ff;
               count_in   = count_ff + 1'b1;
            end
         end
         FN_INSERT: begin
            if (pos_c > cnt_c) begin
               rsp_new.status = ST_RANGE;
            end else if (full) begin
               rsp_new.status = ST_FULL;
            end else begin
               cmd.ins_en = 1'b1;
               count_in   = count_ff + 1'b1;
            end
         end
         FN_DELETE: begin
            if (pos_c >= cnt_c) begin
               rsp_new.status = ST_RANGE;
            end else begin
               cmd.del_en = 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         FN_READ: begin
            if (pos_c >= cnt_c) begin
               rsp_new.status = ST_RANGE;
            end else begin
               rsp_new.read_value = read_mux;
            end
         end
         default: begin
            rsp_new.status = ST_RANGE;
         end
      endcase
      rsp_new.count = CNT_OUT_W'(CMP_W'(count_in));
      if (!accept) begin
         cmd.ins_en = 1'b0;
         cmd.del_en = 1'b0;
         count_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[g+1];
      end
      ilid_cell #(
         .POS_W (CNT_W),
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (shift_pos),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[g])
      );
   end

   ilid_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_rsp    (rsp_new),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_out)
   );

   assign rsp_status     = rsp_out.status;
   assign rsp_count      = rsp_out.count;
   assign rsp_read_value = rsp_out.read_value;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FN_APPEND && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the list");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FN_DELETE && pos_c < cnt_c
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("delete did not shrink the list");

   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

>>> hw/rtl/ilid_cell.sv
// one list entry of the shifting cell chain
// depends on ilid_pkg
module ilid_cell
   import ilid_pkg::*;
#(
   parameter int POS_W = 5,
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  ilid_cmd_type      cmd,
   input  logic [POS_W-1:0]  pos,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              above;
   logic              at_pos;

   assign above  = POS_W'(INDEX) > pos;
   assign at_pos = POS_W'(INDEX) == pos;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins_en) begin
         if (above) begin
            data_in = left_data;
         end else if (at_pos) begin
            data_in = cmd.value;
         end
      end else if (cmd.del_en) begin
         if (above || at_pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> hw/rtl/ilid_rsp_buf.sv
// two-entry result buffer: output register plus skid register
// depends on ilid_pkg
module ilid_rsp_buf
   import ilid_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  ilid_rsp_type in_rsp,
   output logic         out_valid,
   input  logic         out_ready,
   output ilid_rsp_type out_rsp
);

   logic         out_valid_ff;
   logic         out_valid_in;
   ilid_rsp_type out_rsp_ff;
   ilid_rsp_type out_rsp_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   ilid_rsp_type skid_rsp_ff;
   ilid_rsp_type skid_rsp_in;
   logic         accept;

   assign in_ready = !skid_valid_ff;
   assign accept   = in_valid && in_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_rsp_in    = out_rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_rsp_in   = skid_rsp_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_rsp_in    = skid_rsp_ff;
            skid_valid_in = accept;
            skid_rsp_in   = in_rsp;
         end else begin
            out_valid_in = accept;
            out_rsp_in   = in_rsp;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_rsp_in   = in_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_rsp_ff  <= out_rsp_in;
      skid_rsp_ff <= skid_rsp_in;
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

endmodule

>>> dv/tb.sv
// testbench for indexed_list_insert_delete_core: directed and random list operations
// checked against an in-bench list predictor, with random idling and back-pressure
// depends on ilid_pkg and the core rtl
`timescale 1ns / 100ps

module tb
   import ilid_pkg::*;
();

   localparam int CAPACITY    = 16;
   localparam int IDLE_PCT    = 13;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func     = '0;
   logic [4:0]         req_position = '0;
   logic signed [31:0] req_value    = '0;
   logic               rsp_valid;
   logic               rsp_ready    = 1'b0;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_count;
   logic signed [31:0] rsp_read_value;

   logic [31:0]  list_words [CAPACITY];
   int           list_len;
   ilid_rsp_type pending_results [$];
   ilid_rsp_type want_rsp;

   int error_count  = 0;
   int cycle_count  = 0;
   int sent_count   = 0;
   int hold_request = 0;
   int hold_left    = 0;
   bit steady_flow  = 1'b0;
   int status_tally [3];
   int full_hits    = 0;
   int empty_hits   = 0;

   indexed_list_insert_delete_core #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_read_value (rsp_read_value)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic ilid_rsp_type model_list_op(input ilid_func_type fn,
                                                  input logic [4:0] pos,
                                                  input logic [31:0] val);
      ilid_rsp_type r;
      r.status = ST_DONE;
      r.read_value = '0;
      case (fn)
         FN_APPEND: begin
            if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               list_words[list_len] = val;
               list_len++;
            end
         end
         FN_INSERT: begin
            if (pos > list_len) begin
               r.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = val;
               list_len++;
            end
         end
         FN_DELETE: begin
            if (pos >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
               if (list_len == 0) empty_hits++;
            end
         end
         default: begin
            if (pos >= list_len) r.status = ST_RANGE;
            else r.read_value = list_words[pos];
         end
      endcase
      if ((fn == FN_APPEND || fn == FN_INSERT) && r.status == ST_DONE &&
          list_len == CAPACITY) full_hits++;
      r.count = 5'(list_len);
      return r;
   endfunction

   // transaction checker, sampled mid-cycle ahead of the accepting edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result status %0d count %0d read_value %0h",
                     $time, rsp_status, rsp_count, rsp_read_value);
            error_count++;
         end else begin
            want_rsp = pending_results.pop_front();
            if (want_rsp.status <= ST_FULL) status_tally[want_rsp.status]++;
            if (rsp_status !== want_rsp.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, want_rsp.status, rsp_status);
               error_count++;
            end
            if (rsp_count !== want_rsp.count) begin
               $display("%0t: count mismatch, expected %0d actual %0d",
                        $time, want_rsp.count, rsp_count);
               error_count++;
            end
            if (rsp_read_value !== want_rsp.read_value) begin
               $display("%0t: read_value mismatch, expected %0h actual %0h",
                        $time, want_rsp.read_value, rsp_read_value);
               error_count++;
            end
         end
      end
   end

   function automatic int idle_cycles();
      int n;
      n = 0;
      if (!steady_flow) while ($urandom_range(99) < IDLE_PCT) n++;
      return n;
   endfunction

   task automatic send_op(input ilid_func_type fn, input logic [4:0] pos,
                          input logic [31:0] val);
      int gap;
      bit taken;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= fn;
      req_position <= pos;
      req_value    <= val;
      do begin
         @(negedge clock);
         taken = req_ready;
         if (taken) pending_results.push_back(model_list_op(fn, pos, val));
         @(posedge clock);
      end while (!taken);
      sent_count++;
   endtask

   task automatic send_random_op(input int grow_pct);
      ilid_func_type fn;
      logic [4:0] pos;
      if ($urandom_range(99) < 25) fn = FN_READ;
      else if ($urandom_range(99) < grow_pct) fn = $urandom_range(1) ? FN_INSERT : FN_APPEND;
      else fn = FN_DELETE;
      if ($urandom_range(99) < 20) pos = 5'($urandom_range(31));
      else if (fn == FN_INSERT) pos = 5'($urandom_range(list_len));
      else if (list_len > 0) pos = 5'($urandom_range(list_len - 1));
      else pos = '0;
      send_op(fn, pos, $urandom());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_rejects();
      send_op(FN_READ, 5'd0, 32'h0);
      send_op(FN_DELETE, 5'd0, 32'hffff_ffff);
      send_op(FN_INSERT, 5'd1, 32'h1234_5678);
      send_op(FN_READ, 5'd31, 32'h0);
   endtask

   task automatic test_fill_and_edges();
      send_op(FN_INSERT, 5'd0, 32'h7fff_ffff);
      send_op(FN_APPEND, 5'd0, 32'h8000_0000);
      send_op(FN_INSERT, 5'd2, 32'hffff_ffff);
      send_op(FN_INSERT, 5'd1, 32'h0000_0000);
      send_op(FN_READ, 5'd3, 32'h0);
      while (list_len < CAPACITY) send_op(FN_APPEND, 5'($urandom_range(31)), $urandom());
      send_op(FN_APPEND, 5'd0, 32'h5555_aaaa);
      send_op(FN_INSERT, 5'd16, 32'haaaa_5555);
      send_op(FN_INSERT, 5'd17, 32'h1);
      send_op(FN_INSERT, 5'd31, 32'h1);
      send_op(FN_READ, 5'd15, 32'hffff_ffff);
      send_op(FN_READ, 5'd16, 32'h0);
      send_op(FN_DELETE, 5'd31, 32'h0);
      send_op(FN_DELETE, 5'd15, 32'h0);
      send_op(FN_DELETE, 5'd0, 32'hffff_ffff);
      send_op(FN_READ, 5'd0, 32'h0);
   endtask

   task automatic test_random_mix();
      int grow_pct;
      for (int blk = 0; blk < 25; blk++) begin
         case ($urandom_range(2))
            0: grow_pct = 85;
            1: grow_pct = 50;
            default: grow_pct = 15;
         endcase
         steady_flow = (blk >= 10 && blk < 14);
         repeat (40) send_random_op(grow_pct);
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_request = 80;
      repeat (30) send_random_op(60);
   endtask

   task automatic test_drain_pause();
      wait_drained();
      repeat (40) send_random_op(50);
   endtask

   initial begin
      list_len = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_rejects();
      test_fill_and_edges();
      test_random_mix();
      test_backpressure();
      test_drain_pause();
      wait_drained();
      repeat (4) @(posedge clock);
      $display("Sent %0d list operations: %0d done, %0d out-of-range, %0d full rejects",
               sent_count, status_tally[ST_DONE], status_tally[ST_RANGE],
               status_tally[ST_FULL]);
      $display("List filled to capacity %0d times and emptied %0d times",
               full_hits, empty_hits);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
